FILE: rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared constants and types of the 3x3 clamped box blur core.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int unsigned DefMaxWidth  = 4096;
  localparam int unsigned DefMaxHeight = 16384;
  localparam int unsigned ResetWidth   = 4096;
  localparam int unsigned ResetHeight  = 4096;

  localparam int unsigned PixelW   = 8;
  localparam int unsigned OutColW  = 12;
  localparam int unsigned OutRowW  = 14;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned SumW     = 12;   // 9 * 255 + 4 fits
  localparam int unsigned NumRes   = 4;

  // (sum + 4) / 9 as a multiply by ceil(2^16 / 9), exact for sums below 2300
  localparam int unsigned RoundBias = 4;
  localparam int unsigned DivRecip  = 7282;
  localparam int unsigned DivShift  = 16;
  localparam int unsigned RecipW    = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_reg_e;

  typedef logic [PixelW-1:0] pixel_t;
  typedef logic [SumW-1:0]   sum_t;

endpackage

FILE: rtl/box_blur_3x3_clamped_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_clamped_core
// 3x3 box blur of a raster luma stream with edge-replicating borders.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+--------------------------------
//  in       | sink      | in_valid_i / in_stall_o | pixel_in_i
//  out      | source    | out_valid_o/out_stall_i | blurred_value_o, out_column_o,
//           |           |                        | out_row_o, last_result_o
//  cfg      | sink      | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
//  One pixel per clock is accepted unless stalled; results pass stage 1, stage 2
//  and the output register. A pixel causes 0 to 4 results; the serializer emits one
//  per cycle unless stalled; two or more hold the input (row ends, last row).
//  Both line stores share one RAM word per column, read on accept and written
//  back when the pixel leaves stage 1; width 1 frames forward the last written word.
//  No clearing pass after reset: rows are read only after written this frame.
//  A config write restarts the frame.
// ----------------------------------------------------------------------------
module box_blur_3x3_clamped_core
  import bb3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PixelW-1:0]   pixel_in_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PixelW-1:0]   blurred_value_o,
  output logic [OutColW-1:0]  out_column_o,
  output logic [OutRowW-1:0]  out_row_o,
  output logic                last_result_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned ClampW = 18;
  localparam int unsigned WRstM1 = ((ResetWidth > MAX_WIDTH) ? MAX_WIDTH : ResetWidth) - 1;
  localparam int unsigned HRstM1 =
      ((ResetHeight > MAX_HEIGHT) ? MAX_HEIGHT : ResetHeight) - 1;
  localparam int unsigned ProdW = SumW + RecipW;

  typedef logic [CW-1:0] col_t;
  typedef logic [RW-1:0] row_t;

  // ---------------------------------------------------------------- config
  col_t width_m1_q;
  row_t height_m1_q;
  logic [ClampW-1:0] cfg_w_v, cfg_h_v;

  assign cfg_w_v = ClampW'(cfg_wdata_i[12:0]);
  assign cfg_h_v = ClampW'(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_m1_q  <= CW'(WRstM1);
      height_m1_q <= RW'(HRstM1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgImageWidth: begin
          if (cfg_w_v == '0) begin
            width_m1_q <= '0;
          end else if (cfg_w_v > ClampW'(MAX_WIDTH)) begin
            width_m1_q <= CW'(MAX_WIDTH - 1);
          end else begin
            width_m1_q <= CW'(cfg_w_v - ClampW'(1));
          end
        end
        CfgImageHeight: begin
          if (cfg_h_v == '0) begin
            height_m1_q <= '0;
          end else if (cfg_h_v > ClampW'(MAX_HEIGHT)) begin
            height_m1_q <= RW'(MAX_HEIGHT - 1);
          end else begin
            height_m1_q <= RW'(cfg_h_v - ClampW'(1));
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 0
  logic in_acc;
  logic s1_fire;
  logic s1_valid_q;
  col_t col_q, col_d;
  row_t row_q, row_d;

  assign in_stall_o = s1_valid_q & ~s1_fire;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (col_q == width_m1_q) begin
        col_d = '0;
        row_d = (row_q == height_m1_q) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------- stage 1
  pixel_t s1_pix_q;
  col_t   s1_col_q;
  row_t   s1_row_q;
  logic   s1_fwd_q;
  pixel_t lw_newer_q, lw_older_q;
  logic [2*PixelW-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      // the word of this column is written back in the same cycle
      s1_fwd_q   <= s1_fire & (s1_col_q == col_q);
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q <= pixel_in_i;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  pixel_t newer_rd, older_rd;
  pixel_t cur [3];
  pixel_t p1 [3];
  pixel_t p2 [3];
  pixel_t win_q [6];
  logic   row_ge1, row_ge2, col_ge1, col_ge2, col_last, row_last;

  assign newer_rd = s1_fwd_q ? lw_newer_q : ram_rdata[PixelW-1:0];
  assign older_rd = s1_fwd_q ? lw_older_q : ram_rdata[2*PixelW-1:PixelW];
  assign row_ge1  = (s1_row_q != '0);
  assign row_ge2  = (s1_row_q > RW'(1));
  assign col_ge1  = (s1_col_q != '0);
  assign col_ge2  = (s1_col_q > CW'(1));
  assign col_last = (s1_col_q == width_m1_q);
  assign row_last = (s1_row_q == height_m1_q);

  always_comb begin
    cur[2] = s1_pix_q;
    cur[1] = row_ge1 ? newer_rd : s1_pix_q;
    cur[0] = row_ge2 ? older_rd : cur[1];
    for (int i = 0; i < 3; i++) begin
      p1[i] = col_ge1 ? win_q[i] : cur[i];
    end
    for (int i = 0; i < 3; i++) begin
      p2[i] = col_ge2 ? win_q[i+3] : p1[i];
    end
  end

  bb3_ram #(
    .Width (2 * PixelW),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i ({newer_rd, s1_pix_q}),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_fire) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i+3] <= win_q[i];
        win_q[i]   <= cur[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      lw_newer_q <= s1_pix_q;
      lw_older_q <= newer_rd;
    end
  end

  // column sums: upper (r-2, r-1, r) and last-row (r-1, r, r)
  function automatic sum_t col_up(pixel_t a, pixel_t b, pixel_t c);
    return sum_t'(a) + sum_t'(b) + sum_t'(c);
  endfunction

  function automatic sum_t col_lo(pixel_t b, pixel_t c);
    return sum_t'(b) + (sum_t'(c) << 1);
  endfunction

  sum_t up_c, up_1, up_2, lo_c, lo_1, lo_2;
  sum_t s1_sum [NumRes];
  logic [NumRes-1:0] s1_mask;

  always_comb begin
    up_c = col_up(cur[0], cur[1], cur[2]);
    up_1 = col_up(p1[0], p1[1], p1[2]);
    up_2 = col_up(p2[0], p2[1], p2[2]);
    lo_c = col_lo(cur[1], cur[2]);
    lo_1 = col_lo(p1[1], p1[2]);
    lo_2 = col_lo(p2[1], p2[2]);
    // raster order: (c-1,r-1) (c,r-1) (c-1,r) (c,r)
    s1_sum[0] = up_2 + up_1 + up_c;
    s1_sum[1] = up_1 + (up_c << 1);
    s1_sum[2] = lo_2 + lo_1 + lo_c;
    s1_sum[3] = lo_1 + (lo_c << 1);
    s1_mask[0] = row_ge1 & col_ge1;
    s1_mask[1] = row_ge1 & col_last;
    s1_mask[2] = row_last & col_ge1;
    s1_mask[3] = row_last & col_last;
  end

  // ---------------------------------------------------------------- stage 2
  logic [NumRes-1:0] s2_mask_q, s2_mask_d, s2_pick;
  sum_t s2_sum_q [NumRes];
  col_t s2_col_q;
  row_t s2_row_q;
  logic out_valid_q;
  logic out_load_ok, pop;

  assign out_load_ok = ~out_valid_q | ~out_stall_i;
  assign pop         = (s2_mask_q != '0) & out_load_ok;
  assign s2_pick     = s2_mask_q & (~s2_mask_q + NumRes'(1));

  always_comb begin
    s2_mask_d = pop ? (s2_mask_q & ~s2_pick) : s2_mask_q;
  end

  assign s1_fire = s1_valid_q & (s2_mask_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_mask_q <= '0;
    end else if (s1_fire) begin
      s2_mask_q <= s1_mask;
    end else begin
      s2_mask_q <= s2_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      for (int i = 0; i < NumRes; i++) begin
        s2_sum_q[i] <= s1_sum[i];
      end
      s2_col_q <= s1_col_q;
      s2_row_q <= s1_row_q;
    end
  end

  sum_t sel_sum;
  col_t sel_col;
  row_t sel_row;
  logic [ProdW-1:0] prod;

  always_comb begin
    sel_sum = '0;
    for (int i = 0; i < NumRes; i++) begin
      if (s2_pick[i]) begin
        sel_sum = s2_sum_q[i];
      end
    end
    sel_col = (s2_pick[0] | s2_pick[2]) ? s2_col_q - CW'(1) : s2_col_q;
    sel_row = (s2_pick[0] | s2_pick[1]) ? s2_row_q - RW'(1) : s2_row_q;
    prod = ProdW'(sel_sum + SumW'(RoundBias)) * ProdW'(RecipW'(DivRecip));
  end

  // ---------------------------------------------------------------- output
  logic [PixelW-1:0]   out_value_q;
  logic [OutColW-1:0]  out_col_q;
  logic [OutRowW-1:0]  out_row_q;
  logic                out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load_ok) begin
      out_valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_value_q <= prod[DivShift +: PixelW];
      out_col_q   <= OutColW'(sel_col);
      out_row_q   <= OutRowW'(sel_row);
      out_last_q  <= (s2_mask_d == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blurred_value_o = out_value_q;
  assign out_column_o    = out_col_q;
  assign out_row_o       = out_row_q;
  assign last_result_o   = out_last_q;

endmodule

FILE: rtl/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bb3_checker.sv
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks of the box blur core, bound to the top level.
// ----------------------------------------------------------------------------
module bb3_checker
  import bb3_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [PixelW-1:0]  blurred_value_o,
  input logic [OutColW-1:0] out_column_o,
  input logic [OutRowW-1:0] out_row_o,
  input logic               last_result_o
);

  logic out_xfer;
  assign out_xfer = out_valid_o & ~out_stall_i;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(blurred_value_o)
      && $stable(out_column_o) && $stable(out_row_o) && $stable(last_result_o))
    else $error("stalled result changed");

  // results of one pixel leave back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !last_result_o |=> out_valid_o)
    else $error("gap inside the results of one pixel");

  // results of one pixel come in raster order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !last_result_o |=> (out_row_o > $past(out_row_o))
      || (out_row_o == $past(out_row_o) && out_column_o > $past(out_column_o)))
    else $error("results of one pixel out of raster order");

endmodule

bind box_blur_3x3_clamped_core bb3_checker u_bb3_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .blurred_value_o (blurred_value_o),
  .out_column_o    (out_column_o),
  .out_row_o       (out_row_o),
  .last_result_o   (last_result_o)
);
